### rtl/sorted_array_priority_queue_unit_macros.svh
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while in reset.
`define SAPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same check, also live during reset.
`define SAPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/sapq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

   localparam int CAPACITY = 8;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OUT_CNT_W = 4;

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_POP_MIN = 2'd1;
   localparam logic [1:0] MODE_POP_MAX = 2'd2;

   // broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic              pop_min;
      logic [DATA_W-1:0] value;
   } sapq_cmd_type;

endpackage

`default_nettype wire

### rtl/sapq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sapq_req_if;
   import sapq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

### rtl/sapq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sapq_rsp_if;
   import sapq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] removed_value;
   logic                     removed_valid;
   logic                     error;
   logic [OUT_CNT_W-1:0]     entry_count;
   logic signed [DATA_W-1:0] smallest;
   logic signed [DATA_W-1:0] largest;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output removed_value, output removed_valid, output error,
                   output entry_count, output smallest, output largest, output is_empty,
                   output is_full, input ready);
   modport sink (input valid, input removed_value, input removed_valid, input error,
                 input entry_count, input smallest, input largest, input is_empty,
                 input is_full, output ready);
endinterface

`default_nettype wire

### rtl/sapq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sapq_cell (
   input  logic                           clock,
   input  sapq_pkg::sapq_cmd_type         cmd,
   input  logic                           occupied,
   input  logic                           at_end,
   input  logic [sapq_pkg::DATA_W-1:0]    left_value,
   input  logic                           left_greater,
   input  logic [sapq_pkg::DATA_W-1:0]    right_value,
   output logic                           greater,
   output logic [sapq_pkg::DATA_W-1:0]    cur_value,
   output logic [sapq_pkg::DATA_W-1:0]    next_value
);
   import sapq_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   // held entry strictly above the incoming value
   assign greater = occupied && ($signed(value_ff) > $signed(cmd.value));

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (left_greater) begin
            value_in = left_value;
         end else if (greater || at_end) begin
            value_in = cmd.value;
         end
      end else if (cmd.pop_min) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cur_value  = value_ff;
   assign next_value = value_in;
endmodule

`default_nettype wire

### rtl/sorted_array_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Double-ended priority queue of up to CAPACITY (8) signed 32-bit entries, kept
// in ascending order in a row of cells. Each request item inserts a value (placed
// after equal entries), removes the smallest or removes the largest; mode 3 is a
// no-op. Every request gives exactly one response item with the removed value, an
// error flag (insert when full, removal when empty), and the count, smallest,
// largest, empty and full marks after the step. One item per clock: all cells
// compare against the broadcast value and shift in the same cycle, and the
// response sits in an output register, so a new request is taken whenever that
// register is empty or being drained. The response is registered and goes valid in the
// cycle after the accept. Reset clears the count and the response valid flag; cell
// contents need no clearing.

`include "sorted_array_priority_queue_unit_macros.svh"

module sorted_array_priority_queue_unit (
   input  logic       clock,
   input  logic       reset,
   sapq_req_if.sink   req_ch,
   sapq_rsp_if.source rsp_ch
);
   import sapq_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    removed_value_ff, removed_value_in;
   logic                 removed_valid_ff, removed_valid_in;
   logic                 error_ff, error_in;
   logic [OUT_CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [DATA_W-1:0]    smallest_ff, smallest_in;
   logic [DATA_W-1:0]    largest_ff, largest_in;
   logic                 is_empty_ff, is_empty_in;
   logic                 is_full_ff, is_full_in;

   logic accept;
   logic is_ins, is_pop_min, is_pop_max;
   logic full, empty;
   logic do_ins, do_pop_min, do_pop_max;
   sapq_cmd_type cmd;

   logic [CAPACITY-1:0]   occupied;
   logic [CAPACITY-1:0]   at_end;
   logic [CAPACITY-1:0]   greater;
   logic [CAPACITY-1:0]   cur_top;
   logic [CAPACITY-1:0]   next_top;
   logic [DATA_W-1:0]     cur_val  [CAPACITY];
   logic [DATA_W-1:0]     next_val [CAPACITY];
   logic [DATA_W-1:0]     cur_largest, next_largest;
   logic [CNT_W+OUT_CNT_W-1:0] count_wide;
   logic                  rsp_stalled;
   logic                  rsp_took;

   // output register frees as soon as it is taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_ins     = req_ch.mode == MODE_INSERT;
   assign is_pop_min = req_ch.mode == MODE_POP_MIN;
   assign is_pop_max = req_ch.mode == MODE_POP_MAX;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;

   assign do_ins     = accept && is_ins && !full;
   assign do_pop_min = accept && is_pop_min && !empty;
   assign do_pop_max = accept && is_pop_max && !empty;

   always_comb begin
      cmd.ins     = do_ins;
      cmd.pop_min = do_pop_min;
      cmd.value   = req_ch.value;
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop_min || do_pop_max) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // cell row: each cell sees its left and right neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic              left_greater;
      logic [DATA_W-1:0] right_value;

      assign occupied[i] = count_ff > CNT_W'(i);
      assign at_end[i]   = count_ff == CNT_W'(i);
      assign cur_top[i]  = count_ff == CNT_W'(i + 1);
      assign next_top[i] = count_in == CNT_W'(i + 1);

      if (i == 0) begin : g_first
         assign left_value   = '0;
         assign left_greater = 1'b0;
      end else begin : g_mid
         assign left_value   = cur_val[i-1];
         assign left_greater = greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cur_val[i+1];
      end

      sapq_cell u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .occupied     (occupied[i]),
         .at_end       (at_end[i]),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .greater      (greater[i]),
         .cur_value    (cur_val[i]),
         .next_value   (next_val[i])
      );
   end

   // top entry picked by one-hot flags, before and after the step
   always_comb begin
      cur_largest  = '0;
      next_largest = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         cur_largest  = cur_largest  | (cur_val[i]  & {DATA_W{cur_top[i]}});
         next_largest = next_largest | (next_val[i] & {DATA_W{next_top[i]}});
      end
   end

   assign count_wide = {{OUT_CNT_W{1'b0}}, count_in};

   always_comb begin
      removed_value_in = '0;
      if (do_pop_min) begin
         removed_value_in = cur_val[0];
      end else if (do_pop_max) begin
         removed_value_in = cur_largest;
      end
      removed_valid_in = do_pop_min || do_pop_max;
      error_in         = (is_ins && full) || ((is_pop_min || is_pop_max) && empty);
      entry_count_in   = count_wide[OUT_CNT_W-1:0];
      is_empty_in      = count_in == '0;
      is_full_in       = count_in == CNT_W'(CAPACITY);
      smallest_in      = is_empty_in ? '0 : next_val[0];
      largest_in       = next_largest;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_value_ff <= removed_value_in;
         removed_valid_ff <= removed_valid_in;
         error_ff         <= error_in;
         entry_count_ff   <= entry_count_in;
         smallest_ff      <= smallest_in;
         largest_ff       <= largest_in;
         is_empty_ff      <= is_empty_in;
         is_full_ff       <= is_full_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.removed_value = removed_value_ff;
   assign rsp_ch.removed_valid = removed_valid_ff;
   assign rsp_ch.error         = error_ff;
   assign rsp_ch.entry_count   = entry_count_ff;
   assign rsp_ch.smallest      = smallest_ff;
   assign rsp_ch.largest       = largest_ff;
   assign rsp_ch.is_empty      = is_empty_ff;
   assign rsp_ch.is_full       = is_full_ff;

   // checks
   assign rsp_stalled = rsp_valid_ff && !rsp_ch.ready;
   assign rsp_took    = rsp_valid_ff && removed_valid_ff;

   `SAPQ_ASSERT_ALWAYS(a_count_bound, reset || count_ff <= CNT_W'(CAPACITY), "count overflow")
   `SAPQ_ASSERT(a_ins_grows, do_ins |=> count_ff == $past(count_ff) + CNT_W'(1), "insert lost")
   `SAPQ_ASSERT(a_no_take_on_error, rsp_took |-> !error_ff, "take with error")
   `SAPQ_ASSERT(a_hold_when_stalled, rsp_stalled |=> $stable(count_ff), "moved while stalled")

   for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_order_chk
      logic in_order;
      assign in_order = $signed(cur_val[i]) <= $signed(cur_val[i+1]);
      `SAPQ_ASSERT(a_sorted, occupied[i+1] |-> in_order, "row out of order")
   end
endmodule

`default_nettype wire

### tb/sorted_array_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_array_priority_queue_unit_tb;
   import sapq_pkg::*;

   // mode 3 is unused by the block and must act as a no-op
   localparam logic [1:0]        MODE_NOP     = 2'd3;
   localparam logic [DATA_W-1:0] WORD_MIN     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] WORD_MAX     = 32'h7fff_ffff;
   localparam int                RANDOM_ITEMS = 1950;
   localparam int                HOLD_CYCLES  = 300;
   localparam int                CYCLE_LIMIT  = 200000;
   localparam int                REPORT_MAX   = 10;

   // One response item, fields at the block's widths (signs applied when printed).
   typedef struct packed {
      logic [DATA_W-1:0]    removed_value;
      logic                 removed_valid;
      logic                 error;
      logic [OUT_CNT_W-1:0] entry_count;
      logic [DATA_W-1:0]    smallest;
      logic [DATA_W-1:0]    largest;
      logic                 is_empty;
      logic                 is_full;
   } pq_result_type;

   // Scoreboard: keeps a shadow of the sorted queue, works out the response
   // for every accepted request and compares responses in order.
   class pq_scoreboard_type;
      logic signed [DATA_W-1:0] cells [CAPACITY];
      int            held;
      pq_result_type awaited[$];
      int unsigned   mismatches;
      int unsigned   responses_checked;
      int unsigned   inserts_done;
      int unsigned   removals_done;
      int unsigned   error_steps;
      int unsigned   full_steps;

      function new();
         held       = 0;
         mismatches = 0;
         responses_checked = 0;
         inserts_done  = 0;
         removals_done = 0;
         error_steps   = 0;
         full_steps    = 0;
      endfunction

      function string show(pq_result_type r);
         return $sformatf("rv=%0d rvld=%b err=%b cnt=%0d min=%0d max=%0d empty=%b full=%b",
                          $signed(r.removed_value), r.removed_valid, r.error, r.entry_count,
                          $signed(r.smallest), $signed(r.largest), r.is_empty, r.is_full);
      endfunction

      // Accepted request item: update the shadow queue and queue the response.
      function void note_request(logic [1:0] mode, logic signed [DATA_W-1:0] value);
         pq_result_type r;
         int            pos;
         r = '0;
         case (mode)
            MODE_INSERT: begin
               if (held >= CAPACITY) begin
                  r.error = 1'b1;
               end else begin
                  // new value lands after any equal entries
                  pos = held;
                  while (pos > 0 && cells[pos-1] > value) begin
                     cells[pos] = cells[pos-1];
                     pos--;
                  end
                  cells[pos] = value;
                  held++;
                  inserts_done++;
               end
            end
            MODE_POP_MIN, MODE_POP_MAX: begin
               if (held == 0) begin
                  r.error = 1'b1;
               end else if (mode == MODE_POP_MIN) begin
                  r.removed_value = cells[0];
                  for (int k = 1; k < held; k++) cells[k-1] = cells[k];
                  held--;
               end else begin
                  held--;
                  r.removed_value = cells[held];
               end
               if (!r.error) begin
                  r.removed_valid = 1'b1;
                  removals_done++;
               end
            end
            default: ;
         endcase
         r.entry_count = OUT_CNT_W'(held);
         r.smallest    = (held != 0) ? cells[0] : '0;
         r.largest     = (held != 0) ? cells[held-1] : '0;
         r.is_empty    = (held == 0);
         r.is_full     = (held == CAPACITY);
         if (r.error) error_steps++;
         if (r.is_full) full_steps++;
         awaited.push_back(r);
      endfunction

      // Accepted response item: compare field by field with the oldest expectation.
      function void check_result(pq_result_type got);
         pq_result_type want;
         string         diff;
         responses_checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: response with nothing pending: %s", $realtime, show(got));
            return;
         end
         want = awaited.pop_front();
         diff = "";
         if (got.removed_value !== want.removed_value) diff = {diff, " removed_value"};
         if (got.removed_valid !== want.removed_valid) diff = {diff, " removed_valid"};
         if (got.error         !== want.error)         diff = {diff, " error"};
         if (got.entry_count   !== want.entry_count)   diff = {diff, " entry_count"};
         if (got.smallest      !== want.smallest)      diff = {diff, " smallest"};
         if (got.largest       !== want.largest)       diff = {diff, " largest"};
         if (got.is_empty      !== want.is_empty)      diff = {diff, " is_empty"};
         if (got.is_full       !== want.is_full)       diff = {diff, " is_full"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: mismatch in%s\n   expected %s\n   actual   %s",
                        $realtime, diff, show(want), show(got));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sapq_req_if req_ch ();
   sapq_rsp_if rsp_ch ();

   sorted_array_priority_queue_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pq_scoreboard_type sb = new();

   // steady and hold_request are shared between sender and receiver
   bit          steady       = 1'b0;  // no idling on either side while set
   bit          hold_request = 1'b0;  // sender asks the receiver for a long hold-off
   int unsigned items_sent   = 0;
   int unsigned cycles       = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a missing response ends up here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still pending",
                  cycles, sb.awaited.size());
         $display("sorted_array_priority_queue_unit verification failed");
         $finish;
      end
   end

   // Offer one request item, with a random gap in front, and hold it until taken.
   task automatic send_item(input logic [1:0] mode, input logic [DATA_W-1:0] value);
      while (!steady && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= mode;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(mode, value);
      items_sent++;
   endtask

   // Sender pause: let every outstanding response come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Values biased toward the extremes and toward a tight band that forces duplicates.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(5))
         0:       return WORD_MIN + $urandom_range(3);
         1:       return WORD_MAX - $urandom_range(3);
         2, 3:    return $urandom_range(8) - 4;
         default: return $urandom();
      endcase
   endfunction

   // Receiver: checks every accepted response, stalls at random, and serves
   // one long hold-off on request so the output register backs up into the input.
   initial begin : response_side
      int unsigned   hold_left;
      pq_result_type got;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.removed_value = rsp_ch.removed_value;
            got.removed_valid = rsp_ch.removed_valid;
            got.error         = rsp_ch.error;
            got.entry_count   = rsp_ch.entry_count;
            got.smallest      = rsp_ch.smallest;
            got.largest       = rsp_ch.largest;
            got.is_empty      = rsp_ch.is_empty;
            got.is_full       = rsp_ch.is_full;
            sb.check_result(got);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 10);
         end
      end
   end

   initial begin : request_side
      int unsigned      insert_pct;
      int unsigned      pick;
      logic [1:0]       mode;
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_INSERT;
      req_ch.value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: removals and no-op on an empty queue, extreme values and
      // duplicates up to full, insert and no-op while full, then drain from
      // both ends back to empty and one more removal past empty.
      send_item(MODE_POP_MIN, '0);
      send_item(MODE_POP_MAX, '0);
      send_item(MODE_NOP, WORD_MAX);
      send_item(MODE_INSERT, WORD_MAX);
      send_item(MODE_INSERT, WORD_MIN);
      send_item(MODE_INSERT, 32'd0);
      send_item(MODE_INSERT, 32'hffff_ffff);
      send_item(MODE_INSERT, 32'd0);
      send_item(MODE_INSERT, WORD_MIN);
      send_item(MODE_INSERT, WORD_MAX);
      send_item(MODE_INSERT, 32'd1);
      send_item(MODE_INSERT, 32'd5);          // queue is full here
      send_item(MODE_NOP, 32'd7);
      send_item(MODE_POP_MAX, '0);
      send_item(MODE_POP_MIN, '0);
      send_item(MODE_INSERT, 32'h5555_5555);
      send_item(MODE_INSERT, 32'haaaa_aaaa);
      for (int k = 0; k < 4; k++) begin
         send_item(MODE_POP_MIN, '0);
         send_item(MODE_POP_MAX, '0);
      end
      send_item(MODE_POP_MAX, '0);
      wait_drained();

      // Random: the insert share changes every 40 items so the queue keeps
      // swinging between empty and full; a few no-ops mixed in.
      insert_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0:       insert_pct = 20;
               1:       insert_pct = 50;
               default: insert_pct = 80;
            endcase
         end
         steady = (i >= 700 && i < 1000);
         if (i == 1000) wait_drained();
         if (i == 1300) hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 3)
            mode = MODE_NOP;
         else if (pick < 3 + insert_pct)
            mode = MODE_INSERT;
         else
            mode = $urandom_range(1) ? MODE_POP_MAX : MODE_POP_MIN;
         send_item(mode, pick_value());
      end
      req_ch.valid <= 1'b0;

      // Wait for the tail; the watchdog covers a response that never comes.
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d requests: %0d inserts, %0d removals, %0d error steps, %0d steps full",
               items_sent, sb.inserts_done, sb.removals_done, sb.error_steps, sb.full_steps);
      $display("Checked %0d responses, %0d mismatches", sb.responses_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("sorted_array_priority_queue_unit verification clean");
      end else begin
         $display("sorted_array_priority_queue_unit verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/sapq_pkg.sv
rtl/sapq_req_if.sv
rtl/sapq_rsp_if.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue_unit.sv
tb/sorted_array_priority_queue_unit_tb.sv
